>>> sv/mbam_pkg.sv
// ----------------------------------------------------------------------------
// mbam_pkg
// shared constants, types and codes for the bit-vector approximate matcher
// ----------------------------------------------------------------------------
package mbam_pkg;

    // vector and position geometry
    localparam int VECTOR_BITS = 64;
    localparam int POS_BITS    = 32;
    localparam int SCORE_W     = 7;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CMD_W       = 2;
    localparam int SYM_W       = 8;
    localparam int IDX_W       = 6;
    localparam int ROW_W       = SYM_W - 1;
    localparam int ROWS        = 1 << ROW_W;
    localparam int MATCH_END_W = 32;

    // stream packing
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    typedef logic [VECTOR_BITS-1:0] t_vec;
    typedef logic [POS_BITS-1:0]    t_pos;
    typedef logic [SCORE_W-1:0]     t_score;
    typedef logic [ROW_W-1:0]       t_row;

    // input commands
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EOT   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ICASE  = 2'd3;

    // extend modes
    localparam logic [1:0] MODE_REPORT = 2'd0;
    localparam logic [1:0] MODE_BETTER = 2'd1;
    localparam logic [1:0] MODE_SAME   = 2'd2;

    localparam t_score SCORE_MAX = '1;
    localparam t_pos   POS_MAX   = '1;

    // ascii letter bounds
    localparam logic [SYM_W-1:0] CHAR_UA = 8'h41;
    localparam logic [SYM_W-1:0] CHAR_UZ = 8'h5A;
    localparam logic [SYM_W-1:0] CHAR_LA = 8'h61;
    localparam logic [SYM_W-1:0] CHAR_LZ = 8'h7A;

endpackage

>>> sv/myers_bitvector_approx_match_stream_top.sv
// ----------------------------------------------------------------------------
// myers_bitvector_approx_match_stream_top
// streaming edit-distance search of a pattern of up to 64 bytes (Myers)
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                 payload
// s (in)    in   i_s_tvalid / o_s_tready   tdata: symbol, pattern_index; tuser: cmd
// m (out)   out  o_m_tvalid / i_m_tready   tdata: match_end, match_score
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one transaction per cycle is accepted unless the input stalls; the table
// is read at the accepting edge; update-stage results go to the output register
// the update stage holds one 64-bit add of the delta vectors, which sets the clock
// the match-mask table is two 128x64 single-port-write memories split on
// symbol bit 5, so an ignore-case load writes both letter cases in one write-back
// reset clears the per-entry valid bits at once: there is no clearing pass
// a stalled output holds the update stage; the input stalls behind it
//
module myers_bitvector_approx_match_stream_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // symbol [7:0], pattern_index [13:8], zero [15:14]
    input  logic [mbam_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // cmd [1:0]
    input  logic [mbam_pkg::CMD_W-1:0]       i_s_tuser,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // match_end [31:0], match_score [38:32], zero [39]
    output logic [mbam_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbam_pkg::CFG_W-1:0]       i_cfg_data
);
    import mbam_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_eff_len;
    t_vec             r_top;
    t_score           r_thresh;
    logic [1:0]       r_mode;
    logic             r_icase;

    // scan state
    t_vec   r_pv, n_pv;
    t_vec   r_mv, n_mv;
    t_score r_score, n_score;
    t_pos   r_pos, n_pos;
    logic   r_holding, n_holding;
    t_score r_hscore, n_hscore;
    t_pos   r_hend, n_hend;

    // match-mask table, split on symbol bit 5
    t_vec             r_mem_lo [ROWS];
    t_vec             r_mem_hi [ROWS];
    logic [ROWS-1:0]  r_vld_lo, r_vld_hi;
    t_vec             r_rd_lo, r_rd_hi;
    logic             r_rv_lo, r_rv_hi;

    // forwarding of the last table write
    logic   r_fw_lo, r_fw_hi;
    t_row   r_fw_row;
    t_vec   r_fw_lo_data, r_fw_hi_data;

    // update stage
    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    t_row              r_s1_row;
    logic              r_s1_bank;
    logic [IDX_W-1:0]  r_s1_idx;
    logic              r_s1_wr_lo, r_s1_wr_hi;

    // output register
    logic   r_out_valid;
    t_pos   r_out_end;
    t_score r_out_score;

    logic       in_acc, cfg_acc, slot_free, s1_fire;
    logic [SYM_W-1:0] in_sym;
    logic [IDX_W-1:0] in_idx;
    t_row       in_row;
    logic       in_letter, in_range, in_load;
    logic       wr_lo, wr_hi;
    t_vec       lo_old, hi_old, lo_new, hi_new, load_bit;
    t_vec       eq, xv, xh, ph, mh;
    logic       res_valid;
    t_pos       res_end;
    t_score     res_score;
    logic [CFG_W-1:0] cfg_eff;

    assign in_sym = i_s_tdata[SYM_W-1:0];
    assign in_idx = i_s_tdata[SYM_W+IDX_W-1:SYM_W];
    assign in_row = {in_sym[SYM_W-1:6], in_sym[4:0]};

    // output slot frees when empty or being drained
    assign slot_free  = !r_out_valid || i_m_tready;
    assign s1_fire    = r_s1_valid && slot_free;
    assign o_s_tready = !r_s1_valid || slot_free;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc    = i_cfg_valid;

    // load decode at accept: which banks get the bit
    assign in_letter = ((in_sym >= CHAR_UA) && (in_sym <= CHAR_UZ)) ||
                       ((in_sym >= CHAR_LA) && (in_sym <= CHAR_LZ));
    assign in_range  = {1'b0, in_idx} < (IDX_W+1)'(VECTOR_BITS);
    assign in_load   = (i_s_tuser == CMD_LOAD) && in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd   <= i_s_tuser;
            r_s1_row   <= in_row;
            r_s1_bank  <= in_sym[5];
            r_s1_idx   <= in_idx;
            r_s1_wr_lo <= in_load && (!in_sym[5] || (r_icase && in_letter));
            r_s1_wr_hi <= in_load && (in_sym[5] || (r_icase && in_letter));
        end
    end

    // table memories: read at accept, written back from the update stage
    assign wr_lo = s1_fire && r_s1_wr_lo;
    assign wr_hi = s1_fire && r_s1_wr_hi;

    always_ff @(posedge i_clk) begin
        if (wr_lo) begin
            r_mem_lo[r_s1_row] <= lo_new;
        end
        if (in_acc) begin
            r_rd_lo <= r_mem_lo[in_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_hi) begin
            r_mem_hi[r_s1_row] <= hi_new;
        end
        if (in_acc) begin
            r_rd_hi <= r_mem_hi[in_row];
        end
    end

    // valid bits; a clear taken at accept wins over a write-back in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_lo <= '0;
            r_vld_hi <= '0;
        end else if (in_acc && (i_s_tuser == CMD_CLEAR)) begin
            r_vld_lo <= '0;
            r_vld_hi <= '0;
        end else begin
            if (wr_lo) begin
                r_vld_lo[r_s1_row] <= 1'b1;
            end
            if (wr_hi) begin
                r_vld_hi[r_s1_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rv_lo <= r_vld_lo[in_row];
            r_rv_hi <= r_vld_hi[in_row];
        end
    end

    // forward register tracks the write of the item that left the stage last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_lo <= 1'b0;
            r_fw_hi <= 1'b0;
        end else if (s1_fire) begin
            r_fw_lo <= r_s1_wr_lo;
            r_fw_hi <= r_s1_wr_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_fw_row     <= r_s1_row;
            r_fw_lo_data <= lo_new;
            r_fw_hi_data <= hi_new;
        end
    end

    always_comb begin
        if (r_fw_lo && (r_fw_row == r_s1_row)) begin
            lo_old = r_fw_lo_data;
        end else begin
            lo_old = r_rv_lo ? r_rd_lo : '0;
        end
        if (r_fw_hi && (r_fw_row == r_s1_row)) begin
            hi_old = r_fw_hi_data;
        end else begin
            hi_old = r_rv_hi ? r_rd_hi : '0;
        end
        load_bit = t_vec'(1) << r_s1_idx;
        lo_new   = lo_old | load_bit;
        hi_new   = hi_old | load_bit;
    end

    // bit-parallel step
    always_comb begin
        eq = r_s1_bank ? hi_old : lo_old;
        xv = eq | r_mv;
        xh = (((eq & r_pv) + r_pv) ^ r_pv) | eq;
        ph = r_mv | ~(xh | r_pv);
        mh = r_pv & xh;
    end

    // scan update and hit tracking
    always_comb begin
        n_pv      = r_pv;
        n_mv      = r_mv;
        n_score   = r_score;
        n_pos     = r_pos;
        n_holding = r_holding;
        n_hscore  = r_hscore;
        n_hend    = r_hend;
        res_valid = 1'b0;
        res_end   = r_hend;
        res_score = r_hscore;
        if (s1_fire && (r_s1_cmd == CMD_EOT)) begin
            // flush a held run and restart
            res_valid = r_holding;
            n_holding = 1'b0;
            n_pv      = '1;
            n_mv      = '0;
            n_score   = r_eff_len;
            n_pos     = '0;
        end else if (s1_fire && (r_s1_cmd == CMD_TEXT)) begin
            if ((ph & r_top) != '0) begin
                if (r_score != SCORE_MAX) begin
                    n_score = r_score + t_score'(1);
                end
            end else if ((mh & r_top) != '0) begin
                if (r_score != '0) begin
                    n_score = r_score - t_score'(1);
                end
            end
            n_pv = (mh << 1) | ~(xv | (ph << 1));
            n_mv = (ph << 1) & xv;
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + t_pos'(1);
            end
            if (n_score <= r_thresh) begin
                if (r_holding) begin
                    if (n_score < r_hscore) begin
                        n_hscore = n_score;
                        n_hend   = r_pos;
                    end else if (n_score == r_hscore) begin
                        if (r_mode >= MODE_SAME) begin
                            n_hend = r_pos;
                        end
                    end else begin
                        // worse hit ends the run and starts nothing
                        n_holding = 1'b0;
                        res_valid = 1'b1;
                    end
                end else if (r_mode != MODE_REPORT) begin
                    n_hscore  = n_score;
                    n_hend    = r_pos;
                    n_holding = 1'b1;
                end else begin
                    res_valid = 1'b1;
                    res_end   = r_pos;
                    res_score = n_score;
                end
            end else if (r_holding) begin
                n_holding = 1'b0;
                res_valid = 1'b1;
            end
        end
        // pattern length write restarts the vectors and score
        if (cfg_acc && (i_cfg_index == REG_PLEN)) begin
            n_pv    = '1;
            n_mv    = '0;
            n_score = cfg_eff;
        end
    end

    // clamp the written length into 1..VECTOR_BITS
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_eff = CFG_W'(1);
        end else if (i_cfg_data > CFG_W'(VECTOR_BITS)) begin
            cfg_eff = CFG_W'(VECTOR_BITS);
        end else begin
            cfg_eff = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_len <= CFG_W'(1);
            r_top     <= t_vec'(1);
            r_thresh  <= '0;
            r_mode    <= MODE_REPORT;
            r_icase   <= 1'b0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                REG_PLEN: begin
                    r_eff_len <= cfg_eff;
                    r_top     <= t_vec'(1) << (cfg_eff - CFG_W'(1));
                end
                REG_THRESH: r_thresh <= i_cfg_data;
                REG_MODE:   r_mode   <= i_cfg_data[1:0];
                REG_ICASE:  r_icase  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= '1;
            r_mv      <= '0;
            r_score   <= t_score'(1);
            r_pos     <= '0;
            r_holding <= 1'b0;
            r_hscore  <= '0;
            r_hend    <= '0;
        end else begin
            r_pv      <= n_pv;
            r_mv      <= n_mv;
            r_score   <= n_score;
            r_pos     <= n_pos;
            r_holding <= n_holding;
            r_hscore  <= n_hscore;
            r_hend    <= n_hend;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_end   <= res_end;
            r_out_score <= res_score;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_score, MATCH_END_W'(r_out_end)};

    // end of text always leaves the run closed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && (r_s1_cmd == CMD_EOT)) |=> !r_holding)
        else $error("run still held after end of text");

    // a table clear leaves no entry valid, even against a write-back
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_s_tuser == CMD_CLEAR)) |=> ((r_vld_lo == '0) && (r_vld_hi == '0)))
        else $error("table entry valid after clear");

    // input stalls only behind an occupied update stage and a pending output
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with room in the pipeline");

    // a new result never lands on an undrained one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!r_out_valid || i_m_tready))
        else $error("result overwrites a pending output");

endmodule
